// ----- hdl/gffra_pkg.sv -----
// Package for the grid first-fit rectangle allocator.
// Holds sizes, codes and the transfer payload structs; no dependencies.
package gffra_pkg;

    localparam int MAX_COLUMNS = 16;
    localparam int MAX_ROWS    = 16;
    localparam int ID_BITS     = 8;
    localparam int COL_BITS    = $clog2(MAX_COLUMNS);
    localparam int ROW_BITS    = $clog2(MAX_ROWS);
    localparam int ADDR_BITS   = COL_BITS + ROW_BITS;
    localparam int CELL_COUNT  = MAX_COLUMNS * MAX_ROWS;

    localparam logic [1:0] ACT_FIRST_FIT = 2'd0;
    localparam logic [1:0] ACT_AT_WANTED = 2'd1;
    localparam logic [1:0] ACT_REMOVE    = 2'd2;
    localparam logic [1:0] ACT_CLEAR     = 2'd3;

    localparam logic [2:0] ST_PLACED    = 3'd0;
    localparam logic [2:0] ST_NO_ROOM   = 3'd1;
    localparam logic [2:0] ST_REMOVED   = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_CLEARED   = 3'd4;

    localparam logic REG_GRID_COLUMNS = 1'b0;
    localparam logic REG_GRID_ROWS    = 1'b1;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] item_id;
        logic [4:0] item_width;
        logic [4:0] item_height;
        logic [3:0] want_x;
        logic [3:0] want_y;
    } in_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] pos_x;
        logic [3:0] pos_y;
    } out_item_t;

endpackage

// ----- hdl/grid_first_fit_rect_allocator_top.sv -----
// Grid first-fit rectangle allocator, top level.
// Cell owners live in one synchronous RAM; depends on gffra_pkg.
//
// One item is handled at a time. A placement walks candidate positions and, for each, reads
// the covered cells one at a time through the single RAM read port, each read passing a
// read state and a wait state for the registered RAM output; a fill or a remove writes one
// cell per cycle and the remove search reads each active cell at most once. Clear and the
// clearing pass after reset sweep all 256 cells, one per cycle; no item is taken during the
// pass. The result register is loaded at the end and the next item is taken while it waits.
module grid_first_fit_rect_allocator_top
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  gffra_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output gffra_pkg::out_item_t out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [4:0]           cfg_data
);
    import gffra_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DECIDE, S_CHK_RD, S_CHK_WAIT, S_FILL,
        S_RM_RD, S_RM_WAIT, S_RESULT
    } state_t;

    state_t state_reg;
    logic [4:0] cols_reg, rows_reg;
    in_item_t   item_reg;
    logic       wanted_reg;
    logic [4:0] bx_reg, by_reg;
    logic [4:0] cx_reg, cy_reg;
    logic [ADDR_BITS:0] clr_reg;
    logic       fill_zero_reg;
    logic [2:0] st_reg;
    logic       ov_reg;
    logic       cp_reg;
    out_item_t  od_reg;

    logic [ID_BITS-1:0] mem [CELL_COUNT];
    logic [ID_BITS-1:0] rd_reg;
    logic               we;
    logic [ADDR_BITS-1:0] wa, ra;
    logic [ID_BITS-1:0] wd;

    logic [4:0] ac, ar;
    logic [5:0] ex, ey;
    logic [4:0] w, h;
    logic       want_ok;

    assign ac = (cols_reg > 5'(MAX_COLUMNS)) ? 5'(MAX_COLUMNS) : cols_reg;
    assign ar = (rows_reg > 5'(MAX_ROWS)) ? 5'(MAX_ROWS) : rows_reg;
    assign w  = item_reg.item_width;
    assign h  = item_reg.item_height;
    assign ex = {1'b0, bx_reg} + {1'b0, w};
    assign ey = {1'b0, by_reg} + {1'b0, h};
    assign ra = {cy_reg[ROW_BITS-1:0], cx_reg[COL_BITS-1:0]};
    assign want_ok = (in_data.action == ACT_AT_WANTED) &&
                     ({1'b0, in_data.want_x} < ac) &&
                     ({1'b0, in_data.want_y} < ar);

    always_comb
    begin
        we = 1'b0;
        wa = ra;
        wd = fill_zero_reg ? '0 : item_reg.item_id[ID_BITS-1:0];
        if (state_reg == S_CLEAR)
        begin
            we = 1'b1;
            wa = clr_reg[ADDR_BITS-1:0];
            wd = '0;
        end
        else if (state_reg == S_FILL)
        begin
            we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_reg <= mem[ra];
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE) || (state_reg == S_CLEAR);
    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    logic [4:0] fill_x_end, fill_y_end;
    logic       cand_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cols_reg      <= 5'd16;
            rows_reg      <= 5'd16;
            item_reg      <= '0;
            bx_reg        <= '0;
            by_reg        <= '0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            st_reg        <= '0;
            od_reg        <= '0;
            clr_reg       <= '0;
            ov_reg        <= 1'b0;
            cp_reg        <= 1'b0;
            wanted_reg    <= 1'b0;
            fill_zero_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_RESULT && (!ov_reg || !out_stall))
            begin
                ov_reg <= 1'b1;
            end
            else if (ov_reg && !out_stall)
            begin
                ov_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_GRID_COLUMNS)
                begin
                    cols_reg <= cfg_data;
                end
                else
                begin
                    rows_reg <= cfg_data;
                end
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (ADDR_BITS+1)'(CELL_COUNT - 1))
                    begin
                        st_reg    <= ST_CLEARED;
                        bx_reg    <= '0;
                        by_reg    <= '0;
                        cp_reg    <= 1'b0;
                        state_reg <= cp_reg ? S_RESULT : S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid && !in_stall)
                    begin
                        item_reg <= in_data;
                        cx_reg   <= '0;
                        cy_reg   <= '0;
                        unique case (in_data.action)
                            ACT_CLEAR:
                            begin
                                clr_reg   <= '0;
                                cp_reg    <= 1'b1;
                                st_reg    <= ST_CLEARED;
                                state_reg <= S_CLEAR;
                            end
                            ACT_REMOVE:
                            begin
                                if (in_data.item_id == '0 || ac == '0 || ar == '0)
                                begin
                                    st_reg    <= ST_NOT_FOUND;
                                    state_reg <= S_RESULT;
                                end
                                else
                                begin
                                    state_reg <= S_RM_RD;
                                end
                            end
                            default:
                            begin
                                wanted_reg <= want_ok;
                                bx_reg     <= want_ok ? {1'b0, in_data.want_x} : 5'd0;
                                by_reg     <= want_ok ? {1'b0, in_data.want_y} : 5'd0;
                                if (in_data.item_id == '0 || in_data.item_width == '0 ||
                                    in_data.item_height == '0)
                                begin
                                    st_reg    <= ST_NO_ROOM;
                                    state_reg <= S_RESULT;
                                end
                                else
                                begin
                                    state_reg <= S_DECIDE;
                                end
                            end
                        endcase
                    end
                end
                S_DECIDE:
                begin
                    if (cand_ok)
                    begin
                        cx_reg    <= bx_reg;
                        cy_reg    <= by_reg;
                        state_reg <= S_CHK_RD;
                    end
                    else if (wanted_reg)
                    begin
                        wanted_reg <= 1'b0;
                        bx_reg     <= '0;
                        by_reg     <= '0;
                    end
                    else if (ey <= {1'b0, ar} && bx_reg != '0)
                    begin
                        bx_reg <= '0;
                        by_reg <= by_reg + 1'b1;
                    end
                    else
                    begin
                        st_reg    <= ST_NO_ROOM;
                        bx_reg    <= '0;
                        by_reg    <= '0;
                        state_reg <= S_RESULT;
                    end
                end
                S_CHK_RD:
                begin
                    state_reg <= S_CHK_WAIT;
                end
                S_CHK_WAIT:
                begin
                    if (rd_reg != '0)
                    begin
                        if (wanted_reg)
                        begin
                            wanted_reg <= 1'b0;
                            bx_reg     <= '0;
                            by_reg     <= '0;
                        end
                        else
                        begin
                            bx_reg <= bx_reg + 1'b1;
                        end
                        state_reg <= S_DECIDE;
                    end
                    else if (cx_reg + 5'd1 < ex[4:0])
                    begin
                        cx_reg    <= cx_reg + 1'b1;
                        state_reg <= S_CHK_RD;
                    end
                    else if (cy_reg + 5'd1 < ey[4:0])
                    begin
                        cx_reg    <= bx_reg;
                        cy_reg    <= cy_reg + 1'b1;
                        state_reg <= S_CHK_RD;
                    end
                    else
                    begin
                        cx_reg        <= bx_reg;
                        cy_reg        <= by_reg;
                        fill_zero_reg <= 1'b0;
                        st_reg        <= ST_PLACED;
                        state_reg     <= S_FILL;
                    end
                end
                S_FILL:
                begin
                    if (cx_reg + 5'd1 < fill_x_end)
                    begin
                        cx_reg <= cx_reg + 1'b1;
                    end
                    else if (cy_reg + 5'd1 < fill_y_end)
                    begin
                        cx_reg <= bx_reg;
                        cy_reg <= cy_reg + 1'b1;
                    end
                    else
                    begin
                        state_reg <= S_RESULT;
                    end
                end
                S_RM_RD:
                begin
                    state_reg <= S_RM_WAIT;
                end
                S_RM_WAIT:
                begin
                    if (rd_reg == item_reg.item_id[ID_BITS-1:0])
                    begin
                        bx_reg        <= cx_reg;
                        by_reg        <= cy_reg;
                        fill_zero_reg <= 1'b1;
                        st_reg        <= ST_REMOVED;
                        state_reg     <= (w == '0 || h == '0) ? S_RESULT : S_FILL;
                    end
                    else if (cy_reg + 5'd1 < ar)
                    begin
                        cy_reg    <= cy_reg + 1'b1;
                        state_reg <= S_RM_RD;
                    end
                    else if (cx_reg + 5'd1 < ac)
                    begin
                        cy_reg    <= '0;
                        cx_reg    <= cx_reg + 1'b1;
                        state_reg <= S_RM_RD;
                    end
                    else
                    begin
                        st_reg    <= ST_NOT_FOUND;
                        state_reg <= S_RESULT;
                    end
                end
                S_RESULT:
                begin
                    if (!ov_reg || !out_stall)
                    begin
                        od_reg.status   <= st_reg;
                        od_reg.pos_x    <= (st_reg == ST_PLACED || st_reg == ST_REMOVED)
                                           ? bx_reg[3:0] : 4'd0;
                        od_reg.pos_y    <= (st_reg == ST_PLACED || st_reg == ST_REMOVED)
                                           ? by_reg[3:0] : 4'd0;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // clip the fill to the active grid
    always_comb
    begin
        fill_x_end = (ex > {1'b0, ac}) ? ac : ex[4:0];
        fill_y_end = (ey > {1'b0, ar}) ? ar : ey[4:0];
        cand_ok    = (ex <= {1'b0, ac}) && (ey <= {1'b0, ar});
    end

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("input taken while busy");
    a_fill_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL) |-> (cx_reg < ac && cy_reg < ar))
        else $error("fill outside active grid");
    a_check_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHK_RD) |-> cand_ok)
        else $error("candidate checked outside grid");
    a_result_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESULT && !ov_reg) |=> out_valid)
        else $error("result not presented");
`endif

endmodule

// ----- test/tb_grid_first_fit_rect_allocator_top.sv -----
// Testbench for grid_first_fit_rect_allocator_top: directed and random place, remove
// and clear traffic checked against an in-bench grid predictor. Depends on gffra_pkg.
`timescale 1ns / 100ps

module tb_grid_first_fit_rect_allocator_top;
    import gffra_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int DRAIN_CYCLES   = 600;

    typedef struct {
        logic [7:0] id;
        logic [4:0] w;
        logic [4:0] h;
    } placed_rect_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic      cfg_index = 1'b0;
    logic [4:0] cfg_data = '0;

    logic [7:0]   grid_owner [CELL_COUNT];
    int           grid_cols_reg;
    int           grid_rows_reg;
    out_item_t    expected_results [$];
    placed_rect_t placed_rects [$];
    int           errors = 0;
    int           burst_left = 0;
    int           idle_cycles = 0;
    bit           rx_hold = 1'b0;

    grid_first_fit_rect_allocator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic bit rect_free(int x, int y, int w, int h, int ac, int ar);
        if (x + w > ac || y + h > ar)
            return 1'b0;
        for (int cy = y; cy < y + h; cy++)
            for (int cx = x; cx < x + w; cx++)
                if (grid_owner[cy * MAX_COLUMNS + cx] != 0)
                    return 1'b0;
        return 1'b1;
    endfunction

    function automatic void fill_rect(int x, int y, int w, int h, logic [7:0] id,
                                      int ac, int ar);
        for (int cy = y; cy < y + h && cy < ar; cy++)
            for (int cx = x; cx < x + w && cx < ac; cx++)
                grid_owner[cy * MAX_COLUMNS + cx] = id;
    endfunction

    function automatic out_item_t predict_alloc(in_item_t it);
        out_item_t r;
        int ac;
        int ar;
        int w;
        int h;
        int px;
        int py;
        bit ok;
        r  = '0;
        ac = grid_cols_reg > MAX_COLUMNS ? MAX_COLUMNS : grid_cols_reg;
        ar = grid_rows_reg > MAX_ROWS ? MAX_ROWS : grid_rows_reg;
        w  = it.item_width;
        h  = it.item_height;
        px = 0;
        py = 0;
        ok = 1'b0;
        if (it.action == ACT_CLEAR)
        begin
            for (int i = 0; i < CELL_COUNT; i++)
                grid_owner[i] = '0;
            r.status = ST_CLEARED;
        end
        else if (it.action == ACT_REMOVE)
        begin
            if (it.item_id != 0)
                for (int x = 0; x < ac && !ok; x++)
                    for (int y = 0; y < ar && !ok; y++)
                        if (grid_owner[y * MAX_COLUMNS + x] == it.item_id)
                        begin
                            px = x;
                            py = y;
                            ok = 1'b1;
                        end
            if (ok)
            begin
                fill_rect(px, py, w, h, 8'd0, ac, ar);
                r.status = ST_REMOVED;
                r.pos_x  = px[3:0];
                r.pos_y  = py[3:0];
            end
            else
                r.status = ST_NOT_FOUND;
        end
        else
        begin
            if (it.item_id != 0 && w != 0 && h != 0)
            begin
                if (it.action == ACT_AT_WANTED && it.want_x < ac && it.want_y < ar
                    && rect_free(it.want_x, it.want_y, w, h, ac, ar))
                begin
                    px = it.want_x;
                    py = it.want_y;
                    ok = 1'b1;
                end
                else
                    for (int y = 0; y + h <= ar && !ok; y++)
                        for (int x = 0; x + w <= ac && !ok; x++)
                            if (rect_free(x, y, w, h, ac, ar))
                            begin
                                px = x;
                                py = y;
                                ok = 1'b1;
                            end
            end
            if (ok)
            begin
                fill_rect(px, py, w, h, it.item_id, ac, ar);
                r.status = ST_PLACED;
                r.pos_x  = px[3:0];
                r.pos_y  = py[3:0];
            end
            else
                r.status = ST_NO_ROOM;
        end
        return r;
    endfunction

    task automatic send_item(input in_item_t it);
        out_item_t    res;
        placed_rect_t pr;
        int           gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (in_stall);
        res = predict_alloc(it);
        expected_results.insert(expected_results.size(), res);
        if (res.status == ST_PLACED)
        begin
            pr.id = it.item_id;
            pr.w  = it.item_width;
            pr.h  = it.item_height;
            placed_rects.insert(placed_rects.size(), pr);
        end
        else if (res.status == ST_CLEARED)
            placed_rects.delete();
        else if (res.status == ST_REMOVED)
            foreach (placed_rects[i])
                if (placed_rects[i].id == it.item_id)
                begin
                    placed_rects.delete(i);
                    break;
                end
    endtask

    task automatic make_item(output in_item_t it, input logic [1:0] act,
                             input logic [7:0] id, input int w, input int h,
                             input int wx, input int wy);
        it.action      = act;
        it.item_id     = id;
        it.item_width  = w[4:0];
        it.item_height = h[4:0];
        it.want_x      = wx[3:0];
        it.want_y      = wy[3:0];
    endtask

    task automatic wait_idle();
        in_valid   <= 1'b0;
        burst_left = 0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_grid_reg(input logic idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[4:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_GRID_COLUMNS)
            grid_cols_reg = value & 31;
        else
            grid_rows_reg = value & 31;
    endtask

    task automatic set_grid(input int cols, input int rows);
        wait_idle();
        write_grid_reg(REG_GRID_COLUMNS, cols);
        write_grid_reg(REG_GRID_ROWS, rows);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed();
        in_item_t it;
        set_grid(16, 16);
        make_item(it, ACT_FIRST_FIT, 8'd1, 1, 1, 0, 0);      send_item(it);
        make_item(it, ACT_FIRST_FIT, 8'd255, 16, 15, 0, 0);  send_item(it);
        make_item(it, ACT_FIRST_FIT, 8'd2, 16, 1, 0, 0);     send_item(it);
        make_item(it, ACT_FIRST_FIT, 8'd3, 1, 1, 0, 0);      send_item(it);
        make_item(it, ACT_REMOVE, 8'd255, 31, 31, 0, 0);     send_item(it);
        make_item(it, ACT_AT_WANTED, 8'd4, 1, 1, 15, 15);    send_item(it);
        make_item(it, ACT_AT_WANTED, 8'd5, 2, 2, 15, 15);    send_item(it);
        make_item(it, ACT_AT_WANTED, 8'd6, 1, 1, 15, 15);    send_item(it);
        make_item(it, ACT_FIRST_FIT, 8'd0, 1, 1, 0, 0);      send_item(it);
        make_item(it, ACT_FIRST_FIT, 8'd7, 0, 1, 0, 0);      send_item(it);
        make_item(it, ACT_AT_WANTED, 8'd7, 1, 0, 3, 3);      send_item(it);
        make_item(it, ACT_FIRST_FIT, 8'd8, 31, 31, 0, 0);    send_item(it);
        make_item(it, ACT_FIRST_FIT, 8'd9, 17, 1, 0, 0);     send_item(it);
        make_item(it, ACT_REMOVE, 8'd0, 1, 1, 0, 0);         send_item(it);
        make_item(it, ACT_REMOVE, 8'd200, 1, 1, 0, 0);       send_item(it);
        make_item(it, ACT_REMOVE, 8'd1, 1, 1, 0, 0);         send_item(it);
        make_item(it, ACT_CLEAR, 8'd0, 0, 0, 0, 0);          send_item(it);
        make_item(it, ACT_FIRST_FIT, 8'd10, 16, 16, 0, 0);   send_item(it);
        make_item(it, ACT_FIRST_FIT, 8'd11, 1, 1, 0, 0);     send_item(it);
        make_item(it, ACT_CLEAR, 8'hAA, 31, 31, 15, 15);     send_item(it);
    endtask

    task automatic test_grid_extremes();
        in_item_t it;
        set_grid(4, 4);
        make_item(it, ACT_FIRST_FIT, 8'd20, 4, 4, 0, 0);     send_item(it);
        set_grid(0, 5);
        make_item(it, ACT_FIRST_FIT, 8'd21, 1, 1, 0, 0);     send_item(it);
        make_item(it, ACT_REMOVE, 8'd20, 1, 1, 0, 0);        send_item(it);
        set_grid(5, 0);
        make_item(it, ACT_AT_WANTED, 8'd22, 1, 1, 0, 0);     send_item(it);
        set_grid(1, 1);
        make_item(it, ACT_REMOVE, 8'd20, 1, 1, 0, 0);        send_item(it);
        make_item(it, ACT_FIRST_FIT, 8'd23, 1, 1, 0, 0);     send_item(it);
        make_item(it, ACT_FIRST_FIT, 8'd24, 1, 1, 0, 0);     send_item(it);
        set_grid(31, 31);
        make_item(it, ACT_FIRST_FIT, 8'd25, 16, 16, 0, 0);   send_item(it);
        make_item(it, ACT_AT_WANTED, 8'd26, 15, 15, 1, 1);   send_item(it);
        make_item(it, ACT_REMOVE, 8'd20, 4, 4, 0, 0);        send_item(it);
        make_item(it, ACT_CLEAR, 8'd0, 0, 0, 0, 0);          send_item(it);
    endtask

    task automatic random_item(output in_item_t it);
        int          pick;
        int          k;
        logic [31:0] raw;
        pick = $urandom_range(0, 99);
        make_item(it, ACT_FIRST_FIT, 8'($urandom_range(1, 255)),
                  ($urandom_range(0, 9) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 4),
                  ($urandom_range(0, 9) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 4),
                  $urandom_range(0, 15), $urandom_range(0, 15));
        if (pick < 20)
            it.action = ACT_AT_WANTED;
        else if (pick < 47 && placed_rects.size() != 0)
        begin
            k = $urandom_range(0, placed_rects.size() - 1);
            it.action      = ACT_REMOVE;
            it.item_id     = placed_rects[k].id;
            it.item_width  = placed_rects[k].w;
            it.item_height = placed_rects[k].h;
        end
        else if (pick < 50)
            it.action = ACT_CLEAR;
        else if (pick >= 92)
        begin
            raw = $urandom;
            it  = raw[$bits(in_item_t)-1:0];
        end
    endtask

    task automatic test_random(input int count);
        in_item_t it;
        for (int n = 0; n < count; n++)
        begin
            if (n % 150 == 0)
            begin
                if ($urandom_range(0, 4) == 0)
                    set_grid($urandom_range(0, 31), $urandom_range(0, 31));
                else
                    set_grid($urandom_range(1, 16), $urandom_range(1, 16));
            end
            random_item(it);
            send_item(it);
        end
    endtask

    task automatic test_backpressure();
        in_item_t it;
        set_grid(16, 16);
        fork
            begin
                rx_hold = 1'b1;
                repeat (3000) @(posedge clk);
                rx_hold = 1'b0;
            end
            begin
                burst_left = 40;
                for (int n = 0; n < 40; n++)
                begin
                    random_item(it);
                    send_item(it);
                end
            end
        join
    endtask

    always @(posedge clk)
    begin : rx_stall_gen
        int mode;
        int cnt;
        if (cnt == 0)
        begin
            mode = $urandom_range(0, 2);
            cnt  = $urandom_range(16, 128);
        end
        cnt--;
        if (rx_hold)
            out_stall <= 1'b1;
        else if (mode == 0)
            out_stall <= 1'b0;
        else if (mode == 1)
            out_stall <= ($urandom_range(0, 3) == 0);
        else
            out_stall <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin : result_check
        out_item_t exp_r;
        if (out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
                errors++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (out_data.status !== exp_r.status)
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, exp_r.status, out_data.status);
                if (out_data.pos_x !== exp_r.pos_x)
                    $display("%0t: pos_x mismatch, expected %0d, actual %0d",
                             $time, exp_r.pos_x, out_data.pos_x);
                if (out_data.pos_y !== exp_r.pos_y)
                    $display("%0t: pos_y mismatch, expected %0d, actual %0d",
                             $time, exp_r.pos_y, out_data.pos_y);
                if (out_data !== exp_r)
                    errors++;
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < CELL_COUNT; i++)
            grid_owner[i] = '0;
        grid_cols_reg = 16;
        grid_rows_reg = 16;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_grid_extremes();
        test_backpressure();
        test_random(1100);
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- grid_first_fit_rect_allocator_top.f -----
hdl/gffra_pkg.sv
hdl/grid_first_fit_rect_allocator_top.sv
test/tb_grid_first_fit_rect_allocator_top.sv
